FILE: hdl/bolec_pkg.sv
// ----------------------------------------------------------------------------
// bolec_pkg
// Shared codes, command and status types for the ordered list engine.
// ----------------------------------------------------------------------------
package bolec_pkg;

   localparam int ACTION_W = 4;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 6;
   localparam int STATUS_W = 2;

   // request action codes
   localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 4'd0;
   localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 4'd1;
   localparam logic [ACTION_W-1:0] ACT_INSERT_AT  = 4'd2;
   localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 4'd3;
   localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 4'd4;
   localparam logic [ACTION_W-1:0] ACT_REMOVE_AT  = 4'd5;
   localparam logic [ACTION_W-1:0] ACT_READ_AT    = 4'd6;
   localparam logic [ACTION_W-1:0] ACT_DUMP_FWD   = 4'd7;
   localparam logic [ACTION_W-1:0] ACT_DUMP_BACK  = 4'd8;
   localparam logic [ACTION_W-1:0] ACT_CLEAR      = 4'd9;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

   typedef enum logic [2:0] {
      PTR_HOLD = 3'd0,
      PTR_IDX  = 3'd1,
      PTR_TOP  = 3'd2,
      PTR_INC  = 3'd3,
      PTR_DEC  = 3'd4
   } ptr_op_type;

   typedef enum logic [1:0] {
      RES_ZERO  = 2'd0,
      RES_HOLD  = 2'd1,
      RES_RDATA = 2'd2
   } res_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD = 2'd0,
      CNT_INC  = 2'd1,
      CNT_DEC  = 2'd2,
      CNT_CLR  = 2'd3
   } cnt_op_type;

   typedef struct packed {
      logic        capture;
      ptr_op_type  ptr_op;
      logic        rd_en;
      logic        mv_arm;
      logic        mv_up;
      logic        wr_value;
      logic        hold_load;
      logic        emit;
      res_sel_type res_sel;
      logic        last;
      cnt_op_type  cnt_op;
   } cmd_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                err;
      logic                append;
      logic                at_idx;
      logic                at_top;
      logic                dump_end;
      logic                out_free;
   } stat_type;

endpackage

FILE: hdl/bounded_ordered_list_engine_core.sv
// One request at a time. Shifting insert or remove and front push or pop move one entry per
// cycle. A dump sends one reply per element and can stall on the output. An ignored code
// gives no reply. A reply shows in the same cycle that the next request can be taken.
// Synchronous reset empties the list; RAM contents are left as they are.
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_core
// Bounded ordered list with front/back push and pop, indexed insert, remove
// and read, forward and backward dump, and clear.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_core #(
   parameter int CAPACITY = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // [3:0] action, [35:4] value, [41:36] position, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [31:0] value_res
   output logic [1:0]  rsp_tuser,  // [1:0] status
   output logic        rsp_tlast
);
   import bolec_pkg::*;

   cmd_type                   cmd;
   stat_type                  stat;
   logic signed [VALUE_W-1:0] value_res;

   bolec_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   bolec_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_action    (req_tdata[3:0]),
      .req_value     ($signed(req_tdata[35:4])),
      .req_position  (req_tdata[41:36]),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_value_res (value_res),
      .rsp_status    (rsp_tuser),
      .rsp_last      (rsp_tlast)
   );

   assign rsp_tdata = value_res;

endmodule

FILE: hdl/bolec_ram.sv
// ----------------------------------------------------------------------------
// bolec_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bolec_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/bolec_ctrl.sv
// ----------------------------------------------------------------------------
// bolec_ctrl
// Sequencer: decodes the request, runs shift, take and dump sequences.
// ----------------------------------------------------------------------------
module bolec_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output bolec_pkg::cmd_type cmd,
   input  bolec_pkg::stat_type stat
);
   import bolec_pkg::*;

   typedef enum logic [11:0] {
      S_IDLE     = 12'b0000_0000_0001,
      S_DECODE   = 12'b0000_0000_0010,
      S_UP       = 12'b0000_0000_0100,
      S_UP_END   = 12'b0000_0000_1000,
      S_PLACE    = 12'b0000_0001_0000,
      S_TAKE_RD  = 12'b0000_0010_0000,
      S_TAKE_CAP = 12'b0000_0100_0000,
      S_DOWN     = 12'b0000_1000_0000,
      S_DOWN_END = 12'b0001_0000_0000,
      S_RESP     = 12'b0010_0000_0000,
      S_DUMP_RD  = 12'b0100_0000_0000,
      S_DUMP_OUT = 12'b1000_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.err) begin
               state_in = S_RESP;
            end else begin
               unique case (stat.action) inside
                  ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_INSERT_AT: begin
                     if (stat.append) begin
                        cmd.ptr_op = PTR_IDX;
                        state_in   = S_PLACE;
                     end else begin
                        cmd.ptr_op = PTR_TOP;
                        state_in   = S_UP;
                     end
                  end
                  ACT_POP_FRONT, ACT_POP_BACK, ACT_REMOVE_AT, ACT_READ_AT: begin
                     cmd.ptr_op = PTR_IDX;
                     state_in   = S_TAKE_RD;
                  end
                  ACT_DUMP_FWD, ACT_DUMP_BACK: begin
                     cmd.ptr_op = PTR_IDX;
                     state_in   = S_DUMP_RD;
                  end
                  ACT_CLEAR: begin
                     state_in = S_RESP;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_UP: begin
            // read one entry, the datapath writes it one place higher next cycle
            cmd.rd_en  = 1'b1;
            cmd.mv_arm = 1'b1;
            cmd.mv_up  = 1'b1;
            if (stat.at_idx) begin
               state_in = S_UP_END;
            end else begin
               cmd.ptr_op = PTR_DEC;
            end
         end
         S_UP_END: begin
            state_in = S_PLACE;
         end
         S_PLACE: begin
            cmd.wr_value = 1'b1;
            state_in     = S_RESP;
         end
         S_TAKE_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_TAKE_CAP;
         end
         S_TAKE_CAP: begin
            cmd.hold_load = 1'b1;
            if (stat.action == ACT_READ_AT || stat.at_top) begin
               state_in = S_RESP;
            end else begin
               cmd.ptr_op = PTR_INC;
               state_in   = S_DOWN;
            end
         end
         S_DOWN: begin
            cmd.rd_en  = 1'b1;
            cmd.mv_arm = 1'b1;
            if (stat.at_top) begin
               state_in = S_DOWN_END;
            end else begin
               cmd.ptr_op = PTR_INC;
            end
         end
         S_DOWN_END: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            cmd.last = 1'b1;
            if (!stat.err) begin
               unique case (stat.action) inside
                  ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_INSERT_AT: cmd.cnt_op = CNT_INC;
                  ACT_POP_FRONT, ACT_POP_BACK, ACT_REMOVE_AT: begin
                     cmd.cnt_op  = CNT_DEC;
                     cmd.res_sel = RES_HOLD;
                  end
                  ACT_READ_AT: cmd.res_sel = RES_HOLD;
                  ACT_CLEAR:   cmd.cnt_op  = CNT_CLR;
                  default:     cmd.cnt_op  = CNT_HOLD;
               endcase
            end
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.cnt_op = CNT_HOLD;
            end
         end
         S_DUMP_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_DUMP_OUT;
         end
         S_DUMP_OUT: begin
            cmd.res_sel = RES_RDATA;
            cmd.last    = stat.dump_end;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.dump_end) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.ptr_op = (stat.action == ACT_DUMP_FWD) ? PTR_INC : PTR_DEC;
                  state_in   = S_DUMP_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: hdl/bolec_dp.sv
// ----------------------------------------------------------------------------
// bolec_dp
// Datapath: request registers, element count, pointer, element RAM and
// output register.
// ----------------------------------------------------------------------------
module bolec_dp #(
   parameter int CAPACITY = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bolec_pkg::cmd_type                   cmd,
   output bolec_pkg::stat_type                  stat,
   input  logic [bolec_pkg::ACTION_W-1:0]       req_action,
   input  logic signed [bolec_pkg::VALUE_W-1:0] req_value,
   input  logic [bolec_pkg::POS_W-1:0]          req_position,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic signed [bolec_pkg::VALUE_W-1:0] rsp_value_res,
   output logic [bolec_pkg::STATUS_W-1:0]       rsp_status,
   output logic                                 rsp_last
);
   import bolec_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = ((CW > POS_W) ? CW : POS_W) + 1;

   logic [ACTION_W-1:0]       act_ff, act_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [AW-1:0]             ptr_ff, ptr_in;
   logic                      mv_ff, mv_in;
   logic [AW-1:0]             mv_addr_ff, mv_addr_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic                      full, empty, bad_ins, bad_rm;
   logic [EW-1:0]             pos_e, cnt_e;
   logic [AW-1:0]             idx_w, top_w;
   logic [STATUS_W-1:0]       st_code;
   logic                      out_free;
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic [VALUE_W-1:0]        wr_data;
   logic [VALUE_W-1:0]        rd_data;

   // checks against the current count; count only moves when a result leaves
   assign full    = (count_ff >= CW'(CAPACITY));
   assign empty   = (count_ff == '0);
   assign pos_e   = EW'(pos_ff);
   assign cnt_e   = EW'(count_ff);
   assign bad_ins = (pos_e == '0) || (pos_e > cnt_e + EW'(1));
   assign bad_rm  = (pos_e == '0) || (pos_e > cnt_e);
   assign top_w   = AW'(count_ff - CW'(1));

   always_comb begin
      case (act_ff) inside
         ACT_PUSH_BACK:                           idx_w = AW'(count_ff);
         ACT_POP_BACK, ACT_DUMP_BACK:             idx_w = top_w;
         ACT_INSERT_AT, ACT_REMOVE_AT, ACT_READ_AT: idx_w = AW'(pos_e - EW'(1));
         default:                                 idx_w = '0;
      endcase
   end

   always_comb begin
      case (act_ff) inside
         ACT_PUSH_FRONT, ACT_PUSH_BACK: st_code = full ? ST_FULL : ST_OK;
         ACT_INSERT_AT: st_code = full ? ST_FULL : (bad_ins ? ST_BADPOS : ST_OK);
         ACT_POP_FRONT, ACT_POP_BACK, ACT_DUMP_FWD, ACT_DUMP_BACK:
            st_code = empty ? ST_EMPTY : ST_OK;
         ACT_REMOVE_AT, ACT_READ_AT:
            st_code = empty ? ST_EMPTY : (bad_rm ? ST_BADPOS : ST_OK);
         default: st_code = ST_OK;
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      stat          = '0;
      stat.action   = act_ff;
      stat.err      = (st_code != ST_OK);
      stat.append   = (EW'(idx_w) == cnt_e);
      stat.at_idx   = (ptr_ff == idx_w);
      stat.at_top   = (ptr_ff == top_w);
      stat.dump_end = (act_ff == ACT_DUMP_FWD) ? (ptr_ff == top_w) : (ptr_ff == '0);
      stat.out_free = out_free;
   end

   // request capture and hold value
   always_comb begin
      act_in = cmd.capture ? req_action : act_ff;
      pos_in = cmd.capture ? req_position : pos_ff;
      if (cmd.capture) begin
         val_in = req_value;
      end else if (cmd.hold_load) begin
         val_in = $signed(rd_data);
      end else begin
         val_in = val_ff;
      end
   end

   always_comb begin
      case (cmd.ptr_op)
         PTR_IDX: ptr_in = idx_w;
         PTR_TOP: ptr_in = top_w;
         PTR_INC: ptr_in = ptr_ff + AW'(1);
         PTR_DEC: ptr_in = ptr_ff - AW'(1);
         default: ptr_in = ptr_ff;
      endcase
   end

   always_comb begin
      case (cmd.cnt_op)
         CNT_INC: count_in = count_ff + CW'(1);
         CNT_DEC: count_in = count_ff - CW'(1);
         CNT_CLR: count_in = '0;
         default: count_in = count_ff;
      endcase
   end

   // a move writes last cycle's read data one place up or down
   assign mv_in      = cmd.mv_arm;
   assign mv_addr_in = cmd.mv_up ? (ptr_ff + AW'(1)) : (ptr_ff - AW'(1));

   assign wr_en   = mv_ff || cmd.wr_value;
   assign wr_addr = mv_ff ? mv_addr_ff : ptr_ff;
   assign wr_data = mv_ff ? rd_data : val_ff;

   bolec_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in  = cmd.emit || (rsp_valid_ff && !rsp_tready);
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.emit) begin
         case (cmd.res_sel)
            RES_HOLD:  rsp_value_in = val_ff;
            RES_RDATA: rsp_value_in = $signed(rd_data);
            default:   rsp_value_in = '0;
         endcase
         rsp_status_in = st_code;
         rsp_last_in   = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ptr_ff       <= '0;
         mv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         mv_ff        <= mv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      mv_addr_ff    <= mv_addr_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_value_res = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

FILE: dv/tb_bounded_ordered_list_engine_core.sv
// ----------------------------------------------------------------------------
// tb_bounded_ordered_list_engine_core
// Self-checking bench for the ordered list engine. It sends list requests,
// keeps its own copy of the list to work out the replies each one should give,
// and compares every reply field with the oldest outstanding prediction.
// It runs a directed table first, then fills the list to capacity, then a
// random mix, with random idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb_bounded_ordered_list_engine_core;
   import bolec_pkg::*;

   localparam int LIST_DEPTH      = 32;
   localparam int DIRECTED_ROWS   = 24;
   localparam int RANDOM_REQUESTS = 40;
   localparam int HOLD_CYCLES     = 300;
   localparam int MAX_REPORTS     = 10;

   // undefined action codes, ignored by the block
   localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 4'd10;
   localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 4'd15;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [STATUS_W-1:0]       status;
      logic                      last;
   } list_reply_type;

   typedef struct packed {
      logic [ACTION_W-1:0]       act;
      logic signed [VALUE_W-1:0] val;
      logic [POS_W-1:0]          pos;
      logic                      fixed;   // reply typed in below, single result
      logic [STATUS_W-1:0]       status;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // [3:0] action, [35:4] value, [41:36] position, zero fill
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [31:0] value_res
   logic [1:0]  rsp_tuser;   // [1:0] status
   logic        rsp_tlast;

   logic signed [VALUE_W-1:0] list_q[$];
   list_reply_type            awaited[$];

   int  mismatches    = 0;
   int  requests_sent = 0;
   int  replies_seen  = 0;
   int  status_seen [4];
   bit  quiet_sender  = 1'b0;
   bit  hold_replies  = 1'b0;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ACT_POP_FRONT,  32'sd0,            6'd0,  1'b1, ST_EMPTY},
      '{ACT_POP_BACK,   32'sd0,            6'd0,  1'b1, ST_EMPTY},
      '{ACT_REMOVE_AT,  32'sd0,            6'd0,  1'b1, ST_EMPTY},
      '{ACT_READ_AT,    32'sd0,            6'd33, 1'b1, ST_EMPTY},
      '{ACT_DUMP_FWD,   32'sd0,            6'd0,  1'b1, ST_EMPTY},
      '{ACT_DUMP_BACK,  32'sd0,            6'd0,  1'b1, ST_EMPTY},
      '{ACT_CLEAR,      32'sd0,            6'd0,  1'b1, ST_OK},
      '{ACT_INSERT_AT,  32'sd5,            6'd0,  1'b1, ST_BADPOS},
      '{ACT_INSERT_AT,  32'sd5,            6'd2,  1'b1, ST_BADPOS},
      '{ACT_PUSH_FRONT, 32'sh7FFF_FFFF,    6'd0,  1'b1, ST_OK},
      '{ACT_PUSH_BACK,  32'sh8000_0000,    6'd0,  1'b1, ST_OK},
      '{ACT_INSERT_AT,  -32'sd1,           6'd3,  1'b1, ST_OK},
      '{ACT_INSERT_AT,  32'sd0,            6'd1,  1'b1, ST_OK},
      '{ACT_READ_AT,    32'sd0,            6'd4,  1'b0, ST_OK},
      '{ACT_READ_AT,    32'sd0,            6'd5,  1'b1, ST_BADPOS},
      '{ACT_REMOVE_AT,  32'sd0,            6'd0,  1'b1, ST_BADPOS},
      '{ACT_UNUSED_LO,  32'sd7,            6'd1,  1'b0, ST_OK},
      '{ACT_UNUSED_HI,  -32'sd1,           6'd63, 1'b0, ST_OK},
      '{ACT_DUMP_FWD,   32'sd0,            6'd0,  1'b0, ST_OK},
      '{ACT_DUMP_BACK,  32'sd0,            6'd0,  1'b0, ST_OK},
      '{ACT_REMOVE_AT,  32'sd0,            6'd2,  1'b0, ST_OK},
      '{ACT_POP_FRONT,  32'sd0,            6'd0,  1'b0, ST_OK},
      '{ACT_POP_BACK,   32'sd0,            6'd0,  1'b0, ST_OK},
      '{ACT_CLEAR,      32'sd0,            6'd0,  1'b1, ST_OK}
   };

   bounded_ordered_list_engine_core #(
      .CAPACITY (LIST_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Works out the replies of one request and updates the list copy.
   function automatic void apply_list_action(input logic [ACTION_W-1:0] act,
                                             input logic signed [VALUE_W-1:0] val,
                                             input logic [POS_W-1:0] pos,
                                             output list_reply_type outs[$]);
      int n;
      int p;
      n = list_q.size();
      p = int'(pos);
      outs = {};
      case (act)
         ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_INSERT_AT: begin
            if (n >= LIST_DEPTH) begin
               outs.push_back('{'0, ST_FULL, 1'b1});
            end else if (act == ACT_INSERT_AT && (p < 1 || p > n + 1)) begin
               outs.push_back('{'0, ST_BADPOS, 1'b1});
            end else begin
               if (act == ACT_PUSH_FRONT) list_q.push_front(val);
               else if (act == ACT_PUSH_BACK) list_q.push_back(val);
               else list_q.insert(p - 1, val);
               outs.push_back('{'0, ST_OK, 1'b1});
            end
         end
         ACT_POP_FRONT, ACT_POP_BACK, ACT_REMOVE_AT, ACT_READ_AT: begin
            if (n == 0) begin
               outs.push_back('{'0, ST_EMPTY, 1'b1});
            end else if (act == ACT_POP_FRONT) begin
               outs.push_back('{list_q.pop_front(), ST_OK, 1'b1});
            end else if (act == ACT_POP_BACK) begin
               outs.push_back('{list_q.pop_back(), ST_OK, 1'b1});
            end else if (p < 1 || p > n) begin
               outs.push_back('{'0, ST_BADPOS, 1'b1});
            end else begin
               outs.push_back('{list_q[p - 1], ST_OK, 1'b1});
               if (act == ACT_REMOVE_AT) list_q.delete(p - 1);
            end
         end
         ACT_DUMP_FWD, ACT_DUMP_BACK: begin
            if (n == 0) begin
               outs.push_back('{'0, ST_EMPTY, 1'b1});
            end else begin
               for (int k = 0; k < n; k++)
                  outs.push_back('{list_q[(act == ACT_DUMP_FWD) ? k : n - 1 - k], ST_OK,
                                   (k == n - 1)});
            end
         end
         ACT_CLEAR: begin
            list_q.delete();
            outs.push_back('{'0, ST_OK, 1'b1});
         end
         default: ;
      endcase
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $time);
   endtask

   // Offers one request, waits for acceptance, then queues its replies.
   task automatic send_request(input logic [ACTION_W-1:0] act,
                               input logic signed [VALUE_W-1:0] val,
                               input logic [POS_W-1:0] pos,
                               input logic fixed,
                               input logic [STATUS_W-1:0] fixed_status);
      list_reply_type outs[$];
      int gap;
      gap = quiet_sender ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {6'd0, pos, val, act};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      apply_list_action(act, val, pos, outs);
      if (fixed) awaited.push_back('{'0, fixed_status, 1'b1});
      else foreach (outs[i]) awaited.push_back(outs[i]);
      requests_sent++;
      if (requests_sent % 10 == 0) quiet_sender = ($urandom_range(0, 3) == 0);
   endtask

   // Sender stops and waits until every queued reply has come back.
   task automatic drain_replies();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (awaited.size() != 0);
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic void pick_random_request(output logic [ACTION_W-1:0] act,
                                               output logic signed [VALUE_W-1:0] val,
                                               output logic [POS_W-1:0] pos);
      int n;
      int roll;
      int hi;
      n = list_q.size();
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         act = ACT_UNUSED_LO
               + ACTION_W'($urandom_range(0, ACT_UNUSED_HI - ACT_UNUSED_LO));
      end else if (n < 4 && roll < 50) begin
         case ($urandom_range(0, 2))
            0:       act = ACT_PUSH_FRONT;
            1:       act = ACT_PUSH_BACK;
            default: act = ACT_INSERT_AT;
         endcase
      end else if (n > LIST_DEPTH - 4 && roll < 50) begin
         case ($urandom_range(0, 2))
            0:       act = ACT_POP_FRONT;
            1:       act = ACT_POP_BACK;
            default: act = ACT_REMOVE_AT;
         endcase
      end else begin
         act = ACT_PUSH_FRONT
               + ACTION_W'($urandom_range(0, ACT_CLEAR - ACT_PUSH_FRONT));
         // keep clears rare so the list gets deep
         if (act == ACT_CLEAR && $urandom_range(0, 3) != 0) act = ACT_PUSH_BACK;
      end
      val = pick_value();
      hi = (act == ACT_INSERT_AT) ? n + 1 : ((n > 0) ? n : 1);
      if ((act == ACT_INSERT_AT || act == ACT_REMOVE_AT || act == ACT_READ_AT)
          && $urandom_range(0, 4) != 0)
         pos = POS_W'($urandom_range(1, hi));
      else
         pos = POS_W'($urandom_range(0, 33));
   endfunction

   // stimulus
   initial begin : request_side
      logic [ACTION_W-1:0]       act;
      logic signed [VALUE_W-1:0] val;
      logic [POS_W-1:0]          pos;
      int random_taken;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].act, directed_rows[i].val, directed_rows[i].pos,
                      directed_rows[i].fixed, directed_rows[i].status);

      // fill to capacity while the reply side is held off, so the block backs up
      drain_replies();
      hold_replies = 1'b1;
      while (list_q.size() < LIST_DEPTH) begin
         case ($urandom_range(0, 2))
            0:       act = ACT_PUSH_FRONT;
            1:       act = ACT_PUSH_BACK;
            default: act = ACT_INSERT_AT;
         endcase
         pos = POS_W'($urandom_range(1, list_q.size() + 1));
         send_request(act, pick_value(), pos, 1'b0, ST_OK);
      end

      // full list: full wins over a bad position, then a slot is freed and refilled
      send_request(ACT_PUSH_FRONT, 32'sd1, 6'd0, 1'b0, ST_OK);
      send_request(ACT_PUSH_BACK, 32'sd2, 6'd0, 1'b0, ST_OK);
      send_request(ACT_INSERT_AT, 32'sd3, 6'd33, 1'b0, ST_OK);
      send_request(ACT_INSERT_AT, 32'sd4, 6'd0, 1'b0, ST_OK);
      send_request(ACT_READ_AT, 32'sd0, 6'd32, 1'b0, ST_OK);
      send_request(ACT_READ_AT, 32'sd0, 6'd33, 1'b0, ST_OK);
      send_request(ACT_REMOVE_AT, 32'sd0, 6'd33, 1'b0, ST_OK);
      send_request(ACT_DUMP_BACK, 32'sd0, 6'd0, 1'b0, ST_OK);
      send_request(ACT_REMOVE_AT, 32'sd0, 6'd32, 1'b0, ST_OK);
      send_request(ACT_INSERT_AT, pick_value(), 6'd32, 1'b0, ST_OK);
      send_request(ACT_INSERT_AT, pick_value(), 6'd33, 1'b0, ST_OK);
      send_request(ACT_DUMP_FWD, 32'sd0, 6'd0, 1'b0, ST_OK);

      random_taken = 0;
      while (random_taken < RANDOM_REQUESTS) begin
         pick_random_request(act, val, pos);
         send_request(act, val, pos, 1'b0, ST_OK);
         if (act <= ACT_CLEAR) random_taken++;
      end

      drain_replies();
      repeat (100) @(posedge clock);

      $display("Ran %0d requests: directed table, fill to capacity with full-list probes,",
               requests_sent);
      $display("random mix; %0d replies (ok %0d, empty %0d, full %0d, bad position %0d).",
               replies_seen, status_seen[ST_OK], status_seen[ST_EMPTY],
               status_seen[ST_FULL], status_seen[ST_BADPOS]);
      if (awaited.size() != 0)
         $display("%0d replies never arrived", awaited.size());
      if (mismatches == 0 && awaited.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // reply side: random stalls, quiet stretches, one long hold-off on request
   initial begin : reply_side
      int gap;
      int taken;
      rsp_tready <= 1'b0;
      taken = 0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_replies) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_replies = 1'b0;
         end
         if (taken % 16 == 0) gap = ($urandom_range(0, 3) == 0) ? -1 : 0;
         gap = (gap < 0) ? -1 : $urandom_range(0, 17);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         taken++;
      end
   end

   always @(posedge clock) begin : reply_check
      list_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         replies_seen++;
         status_seen[rsp_tuser]++;
         if (awaited.size() == 0) begin
            note_mismatch("reply with nothing outstanding, value_res", '0, rsp_tdata);
         end else begin
            want = awaited.pop_front();
            if (rsp_tdata !== want.value) note_mismatch("value_res", want.value, rsp_tdata);
            if (rsp_tuser !== want.status) note_mismatch("status", want.status, rsp_tuser);
            if (rsp_tlast !== want.last) note_mismatch("last", want.last, rsp_tlast);
         end
      end
   end

   initial begin : watchdog
      #2000000;
      $display("Timeout: %0d replies still outstanding", awaited.size());
      $display("Some tests failed");
      $finish;
   end

endmodule
